// ----- hw/rtl/mssc_pkg.sv -----
package mssc_pkg;

  // one request: an instruction to execute or a data byte to preload
  typedef struct packed {
    logic        req_type;
    logic [31:0] instr_word;
    logic [15:0] preload_addr;
    logic [7:0]  preload_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic        store_done;
    logic [15:0] store_addr;
    logic [31:0] store_word;
  } rsp_t;

  // data memory access, address taken modulo the memory size inside
  typedef struct packed {
    logic        rd_word;
    logic        wr_word;
    logic        wr_byte;
    logic [31:0] addr;
    logic [31:0] wdata;
  } dmem_req_t;

  localparam logic REQ_EXEC    = 1'b0;
  localparam logic REQ_PRELOAD = 1'b1;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_NOR  = 6'd39;

  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

endpackage

// ----- hw/rtl/mssc_dmem.sv -----
module mssc_dmem #(
  parameter int unsigned DATA_MEM_BYTES = 65536
) (
  input  logic                clk_i,
  input  mssc_pkg::dmem_req_t req_i,
  output logic [31:0]         rdata_o
);
  import mssc_pkg::*;

  localparam int unsigned AddrW = $clog2(DATA_MEM_BYTES);
  localparam int unsigned RowW  = AddrW - 2;
  localparam int unsigned Rows  = DATA_MEM_BYTES / 4;

  logic [AddrW-1:0] addr;
  logic [1:0]       lane;
  logic [RowW-1:0]  row_base;
  logic [1:0]       lane_q;
  logic [7:0]       bank_rd_q [4];

  assign addr     = req_i.addr[AddrW-1:0];
  assign lane     = addr[1:0];
  assign row_base = addr[AddrW-1:2];

  // four byte banks interleaved on the low address bits, so an unaligned
  // word touches each bank once; banks below the start lane use the next row
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]      mem [Rows];
    logic [RowW-1:0] row;
    logic [1:0]      k;
    logic            we;
    logic [7:0]      wd;

    assign row = row_base + RowW'(2'(j) < lane);
    assign k   = 2'(j) - lane;
    assign we  = req_i.wr_word | (req_i.wr_byte & (lane == 2'(j)));
    assign wd  = req_i.wr_byte ? req_i.wdata[7:0] : req_i.wdata[{2'd3 - k, 3'b000} +: 8];

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[row] <= wd;
      end
      if (req_i.rd_word) begin
        bank_rd_q[j] <= mem[row];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_word) begin
      lane_q <= lane;
    end
  end

  // big-endian: the byte at the start address is the most significant
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdata_o[8*(3-k) +: 8] = bank_rd_q[2'(lane_q + 2'(k))];
    end
  end

endmodule

// ----- hw/rtl/mips_subset_single_cycle_core.sv -----
// MIPS32 subset core (addu, subu, and, or, nor, addiu, beq, lw, sw, j and the all-ones
// halt word) that executes one instruction or one data-byte preload per request and
// answers each with one response carrying the next pc, the halt flag, the register
// writeback and the store. Requests go through three registered steps: register file
// read at acceptance, execute with data memory access, then writeback into the output
// register. One request enters per cycle while neither output back-pressure nor a
// load stall holds the pipeline; an instruction that reads the destination of the
// load just ahead of it waits, because load data returns from the synchronous data
// memory only in the writeback step. The data memory is DATA_MEM_BYTES bytes
// (a power of two), built from four byte-wide banks so an unaligned word wraps at the
// end of memory; its contents are undefined until preloaded or stored. Registers read
// as zero after reset and register zero is never written.
module mips_subset_single_cycle_core #(
  parameter int unsigned DATA_MEM_BYTES = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mssc_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mssc_pkg::rsp_t out_rsp_o
);
  import mssc_pkg::*;

  localparam int unsigned AddrW = $clog2(DATA_MEM_BYTES);

  logic        in_accept;
  logic        s1_move;
  logic        s2_move;
  logic        load_hazard;

  logic        s1_valid_q;
  req_t        s1_req_q;
  logic        s2_valid_q;
  rsp_t        s2_rsp_q;
  logic        s2_lw_q;
  logic        out_valid_q;
  rsp_t        out_rsp_q;

  logic [31:0] pc_q, pc_d;
  logic        halt_q, halt_d;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_a_q, rf_b_q;
  logic [31:0] rf_vld_q;
  logic        vld_a_q, vld_b_q;
  logic        ovr_a_q, ovr_b_q;
  logic [31:0] ovr_val_a_q, ovr_val_b_q;
  logic        hit_a, hit_b;
  logic [4:0]  rs_sel, rt_sel;
  logic [4:0]  in_rs, in_rt, s1_rs, s1_rt;

  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;

  logic        fwd_a, fwd_b;
  logic [31:0] op_a, op_b;

  rsp_t        s1_rsp;
  logic        s1_lw;
  dmem_req_t   dm_req;
  logic [31:0] dm_rdata;
  rsp_t        s2_out;

  assign in_rs = in_req_i.instr_word[25:21];
  assign in_rt = in_req_i.instr_word[20:16];
  assign s1_rs = s1_req_q.instr_word[25:21];
  assign s1_rt = s1_req_q.instr_word[20:16];

  // handshake and stage control
  assign s2_move     = s2_valid_q & (~out_valid_q | out_ready_i);
  assign load_hazard = s2_valid_q & s2_lw_q & s2_rsp_q.reg_written &
                       ((s2_rsp_q.dest_reg == s1_rs) | (s2_rsp_q.dest_reg == s1_rt));
  assign s1_move     = s1_valid_q & ~load_hazard & (~s2_valid_q | s2_move);
  assign in_ready_o  = ~s1_valid_q | s1_move;
  assign in_accept   = in_valid_i & in_ready_o;

  // writeback
  assign rf_we    = s2_move & s2_rsp_q.reg_written;
  assign rf_waddr = s2_rsp_q.dest_reg;
  assign rf_wdata = s2_lw_q ? dm_rdata : s2_rsp_q.dest_value;

  always_comb begin
    s2_out = s2_rsp_q;
    if (s2_lw_q) begin
      s2_out.dest_value = dm_rdata;
    end
  end

  // a write that lands after the read was issued overrides the read data
  assign rs_sel = in_accept ? in_rs : s1_rs;
  assign rt_sel = in_accept ? in_rt : s1_rt;
  assign hit_a  = rf_we & (rf_waddr == rs_sel);
  assign hit_b  = rf_we & (rf_waddr == rt_sel);

  // result still in the memory step is forwarded; a pending load stalls instead
  assign fwd_a = s2_valid_q & ~s2_lw_q & s2_rsp_q.reg_written & (s2_rsp_q.dest_reg == s1_rs);
  assign fwd_b = s2_valid_q & ~s2_lw_q & s2_rsp_q.reg_written & (s2_rsp_q.dest_reg == s1_rt);

  assign op_a = fwd_a ? s2_rsp_q.dest_value :
                ovr_a_q ? ovr_val_a_q :
                vld_a_q ? rf_a_q : '0;
  assign op_b = fwd_b ? s2_rsp_q.dest_value :
                ovr_b_q ? ovr_val_b_q :
                vld_b_q ? rf_b_q : '0;

  // execute
  always_comb begin
    logic [31:0] ins;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] eaddr;
    logic [31:0] saddr_ext;
    logic        wr;
    logic [4:0]  wreg;
    logic [31:0] wval;

    ins       = s1_req_q.instr_word;
    op        = ins[31:26];
    fn        = ins[5:0];
    simm      = {{16{ins[15]}}, ins[15:0]};
    pc4       = pc_q + 32'd4;
    eaddr     = op_a + simm;
    saddr_ext = 32'(eaddr[AddrW-1:0]);
    wr        = 1'b0;
    wreg      = '0;
    wval      = '0;
    s1_rsp    = '0;
    s1_lw     = 1'b0;
    dm_req    = '0;
    pc_d      = pc_q;
    halt_d    = halt_q;

    if (s1_req_q.req_type == REQ_PRELOAD) begin
      dm_req.wr_byte = 1'b1;
      dm_req.addr    = {16'b0, s1_req_q.preload_addr};
      dm_req.wdata   = {24'b0, s1_req_q.preload_byte};
    end else if (!halt_q) begin
      if (ins == HALT_WORD) begin
        halt_d = 1'b1;
      end else begin
        pc_d = pc4;
        case (op)
          OP_RTYPE: begin
            wr   = 1'b1;
            wreg = ins[15:11];
            case (fn)
              FN_ADDU: wval = op_a + op_b;
              FN_SUBU: wval = op_a - op_b;
              FN_AND:  wval = op_a & op_b;
              FN_OR:   wval = op_a | op_b;
              FN_NOR:  wval = ~(op_a | op_b);
              default: wval = '0;
            endcase
          end
          OP_J: begin
            pc_d = {pc4[31:28], ins[25:0], 2'b00};
          end
          OP_BEQ: begin
            if (op_a == op_b) begin
              pc_d = pc4 + {simm[29:0], 2'b00};
            end
          end
          OP_ADDIU: begin
            wr   = 1'b1;
            wreg = ins[20:16];
            wval = eaddr;
          end
          OP_LW: begin
            wr             = 1'b1;
            wreg           = ins[20:16];
            s1_lw          = 1'b1;
            dm_req.rd_word = 1'b1;
            dm_req.addr    = eaddr;
          end
          OP_SW: begin
            dm_req.wr_word    = 1'b1;
            dm_req.addr       = eaddr;
            dm_req.wdata      = op_b;
            s1_rsp.store_done = 1'b1;
            s1_rsp.store_addr = saddr_ext[15:0];
            s1_rsp.store_word = op_b;
          end
          default: begin
          end
        endcase
      end
    end

    if (wr && (wreg != '0)) begin
      s1_rsp.reg_written = 1'b1;
      s1_rsp.dest_reg    = wreg;
      s1_rsp.dest_value  = s1_lw ? '0 : wval;
    end else begin
      s1_lw          = 1'b0;
      dm_req.rd_word = 1'b0;
    end
    s1_rsp.next_pc = pc_d;
    s1_rsp.halted  = halt_d;

    if (!s1_move) begin
      dm_req.rd_word = 1'b0;
      dm_req.wr_word = 1'b0;
      dm_req.wr_byte = 1'b0;
    end
  end

  mssc_dmem #(
    .DATA_MEM_BYTES(DATA_MEM_BYTES)
  ) u_dmem (
    .clk_i  (clk_i),
    .req_i  (dm_req),
    .rdata_o(dm_rdata)
  );

  // register file storage, read on acceptance
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (in_accept) begin
      rf_a_q <= rf_mem[in_rs];
      rf_b_q <= rf_mem[in_rt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      rf_vld_q    <= '0;
      vld_a_q     <= 1'b0;
      vld_b_q     <= 1'b0;
      ovr_a_q     <= 1'b0;
      ovr_b_q     <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_q <= 1'b1;
      end else if (s2_move) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_move) begin
        pc_q   <= pc_d;
        halt_q <= halt_d;
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (in_accept) begin
        vld_a_q <= rf_vld_q[in_rs];
        vld_b_q <= rf_vld_q[in_rt];
      end
      ovr_a_q <= hit_a | (~in_accept & ovr_a_q);
      ovr_b_q <= hit_b | (~in_accept & ovr_b_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q <= in_req_i;
    end
    if (s1_move) begin
      s2_rsp_q <= s1_rsp;
      s2_lw_q  <= s1_lw;
    end
    if (s2_move) begin
      out_rsp_q <= s2_out;
    end
    if (hit_a) begin
      ovr_val_a_q <= rf_wdata;
    end
    if (hit_b) begin
      ovr_val_b_q <= rf_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- hw/rtl/mssc_checker.sv -----
module mssc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mssc_pkg::rsp_t out_rsp_o
);
  import mssc_pkg::*;

  logic        in_acc;
  logic        out_acc;
  logic [2:0]  cnt_q;
  logic        seen_halt_q;
  logic [31:0] last_pc_q;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // requests accepted and not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      seen_halt_q <= 1'b0;
    end else begin
      cnt_q <= 3'(cnt_q + {2'b0, in_acc} - {2'b0, out_acc});
      if (out_acc && out_rsp_o.halted) begin
        seen_halt_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      last_pc_q <= out_rsp_o.next_pc;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("more requests in flight than pipeline slots");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("response without an outstanding request");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_halt_q |-> out_rsp_o.halted && out_rsp_o.next_pc == last_pc_q)
    else $error("core left the halted state or moved its pc");

endmodule

bind mips_subset_single_cycle_core mssc_checker u_mssc_checker (.*);
